// ===== hw/rtl/ray_unit_box_slab_intersect_defines.svh =====
// Assertion macros for the box slab intersect block.
`ifndef RAY_UNIT_BOX_SLAB_INTERSECT_DEFINES_SVH
`define RAY_UNIT_BOX_SLAB_INTERSECT_DEFINES_SVH
`ifndef SYNTH
`define RUSI_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define RUSI_ASSERT_IMPL(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`else
`define RUSI_ASSERT(name, clk, rst, prop)
`define RUSI_ASSERT_IMPL(name, clk, rst, pre, post)
`endif
`endif

// ===== hw/rtl/rusi_pkg.sv =====
`timescale 1ns / 1ps
package rusi_pkg;

   localparam int FRAC_BITS_DEF      = 16;
   localparam int DIV_BITS_PER_STAGE = 4;
   localparam int FACE_LAT           = 3;

   localparam logic [2:0] FACE_POS_X = 3'd0;
   localparam logic [2:0] FACE_NEG_X = 3'd1;
   localparam logic [2:0] FACE_POS_Y = 3'd2;
   localparam logic [2:0] FACE_NEG_Y = 3'd3;
   localparam logic [2:0] FACE_POS_Z = 3'd4;
   localparam logic [2:0] FACE_NEG_Z = 3'd5;

   localparam logic [16:0] UV_ONE = 17'h10000;

   localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] T_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
   } req_type;

   typedef struct packed {
      logic               is_hit;
      logic signed [31:0] t_enter;
      logic signed [31:0] t_exit;
      logic [2:0]         enter_face;
      logic [2:0]         exit_face;
      logic [16:0]        enter_u;
      logic [16:0]        enter_v;
      logic [16:0]        exit_u;
      logic [16:0]        exit_v;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  face;
      logic [16:0] u;
      logic [16:0] v;
   } face_res_type;

endpackage

// ===== hw/rtl/ray_unit_box_slab_intersect.sv =====
`timescale 1ns / 1ps
// Throughput: one ray per cycle, every cycle; the radix-16 slab dividers set the depth.
// busy is high only while reset is held and the cycle after; it never blocks otherwise.
// Reset is synchronous and clears the valid bits of every stage; no result follows reset.
`include "ray_unit_box_slab_intersect_defines.svh"
module ray_unit_box_slab_intersect import rusi_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   localparam int NUM_W = 33 + FRAC_BITS;
   localparam int NDS   = (NUM_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
   localparam int L_DIV = NDS + 1;
   localparam logic signed [32:0] HALF = 33'sd1 <<< (FRAC_BITS - 1);

   typedef struct packed {
      req_type    ray;
      logic [2:0] dz;
      logic [2:0] ok;
   } side_type;

   logic busy_ff;
   logic accept;

   // stage A
   logic    a_vld_ff;
   req_type a_ray_ff;

   logic signed [31:0] o_a [3];
   logic signed [31:0] d_a [3];
   logic [NUM_W-1:0]   num_near [3];
   logic [NUM_W-1:0]   num_far [3];
   logic               neg_near [3];
   logic               neg_far [3];
   logic [31:0]        den [3];
   logic signed [31:0] tn_div [3];
   logic signed [31:0] tf_div [3];
   side_type           a_side;

   side_type side_ff [L_DIV];
   logic     svld_ff [L_DIV];

   // stage C
   logic               c_vld_ff, c_hit_ff, c_hit_in;
   logic signed [31:0] c_tmin_ff, c_tmin_in, c_tmax_ff, c_tmax_in;
   req_type            c_ray_ff;

   logic               f_vld_ff [FACE_LAT];
   logic               f_hit_ff [FACE_LAT];
   logic signed [31:0] f_tmin_ff [FACE_LAT];
   logic signed [31:0] f_tmax_ff [FACE_LAT];

   face_res_type enter_res, exit_res;

   logic    rsp_strobe_ff;
   rsp_type rsp_ff, rsp_in;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      logic signed [32:0] o33, nn, nf;
      logic [32:0]        mn, mf;
      o_a[0] = a_ray_ff.origin_x;
      o_a[1] = a_ray_ff.origin_y;
      o_a[2] = a_ray_ff.origin_z;
      d_a[0] = a_ray_ff.dir_x;
      d_a[1] = a_ray_ff.dir_y;
      d_a[2] = a_ray_ff.dir_z;
      a_side.ray = a_ray_ff;
      for (int i = 0; i < 3; i++) begin
         o33 = 33'(o_a[i]);
         // near bound is +0.5 for a falling component, -0.5 otherwise
         nn  = (d_a[i][31] ? HALF : -HALF) - o33;
         nf  = (d_a[i][31] ? -HALF : HALF) - o33;
         mn  = nn[32] ? 33'(-nn) : 33'(nn);
         mf  = nf[32] ? 33'(-nf) : 33'(nf);
         num_near[i] = {mn, {FRAC_BITS{1'b0}}};
         num_far[i]  = {mf, {FRAC_BITS{1'b0}}};
         neg_near[i] = nn[32] ^ d_a[i][31];
         neg_far[i]  = nf[32] ^ d_a[i][31];
         den[i]      = d_a[i][31] ? 32'(-d_a[i]) : 32'(d_a[i]);
         a_side.dz[i] = (d_a[i] == 32'sd0);
         a_side.ok[i] = (d_a[i] != 32'sd0) || (o33 >= -HALF && o33 <= HALF);
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_axis
      rusi_slab_div #(.NUM_W(NUM_W), .BPS(DIV_BITS_PER_STAGE)) u_div_near (
         .clock   (clock),
         .num_mag (num_near[i]),
         .den_mag (den[i]),
         .quo_neg (neg_near[i]),
         .quo_sat (tn_div[i])
      );
      rusi_slab_div #(.NUM_W(NUM_W), .BPS(DIV_BITS_PER_STAGE)) u_div_far (
         .clock   (clock),
         .num_mag (num_far[i]),
         .den_mag (den[i]),
         .quo_neg (neg_far[i]),
         .quo_sat (tf_div[i])
      );
   end

   // slab overlap: x against y, then the combined range against z
   always_comb begin
      logic signed [31:0] tn [3];
      logic signed [31:0] tf [3];
      logic signed [31:0] mn1, mx1;
      side_type           sd;
      sd = side_ff[L_DIV-1];
      for (int i = 0; i < 3; i++) begin
         tn[i] = sd.dz[i] ? T_MIN : tn_div[i];
         tf[i] = sd.dz[i] ? T_MAX : tf_div[i];
      end
      mn1 = (tn[1] > tn[0]) ? tn[1] : tn[0];
      mx1 = (tf[1] < tf[0]) ? tf[1] : tf[0];
      c_tmin_in = (tn[2] > mn1) ? tn[2] : mn1;
      c_tmax_in = (tf[2] < mx1) ? tf[2] : mx1;
      c_hit_in  = (&sd.ok) && !(tn[0] > tf[1]) && !(tn[1] > tf[0])
                  && !(mn1 > tf[2]) && !(tn[2] > mx1);
   end

   rusi_face #(.FRAC_BITS(FRAC_BITS)) u_face_enter (
      .clock (clock),
      .ray   (c_ray_ff),
      .t     (c_tmin_ff),
      .res   (enter_res)
   );

   rusi_face #(.FRAC_BITS(FRAC_BITS)) u_face_exit (
      .clock (clock),
      .ray   (c_ray_ff),
      .t     (c_tmax_ff),
      .res   (exit_res)
   );

   always_comb begin
      rsp_in = '0;
      if (f_hit_ff[FACE_LAT-1]) begin
         rsp_in.is_hit     = 1'b1;
         rsp_in.t_enter    = f_tmin_ff[FACE_LAT-1];
         rsp_in.t_exit     = f_tmax_ff[FACE_LAT-1];
         rsp_in.enter_face = enter_res.face;
         rsp_in.exit_face  = exit_res.face;
         rsp_in.enter_u    = enter_res.u;
         rsp_in.enter_v    = enter_res.v;
         rsp_in.exit_u     = exit_res.u;
         rsp_in.exit_v     = exit_res.v;
      end
   end

   always_ff @(posedge clock) begin
      a_ray_ff   <= req_payload;
      side_ff[0] <= a_side;
      for (int s = 1; s < L_DIV; s++) side_ff[s] <= side_ff[s-1];
      c_ray_ff     <= side_ff[L_DIV-1].ray;
      c_hit_ff     <= c_hit_in;
      c_tmin_ff    <= c_tmin_in;
      c_tmax_ff    <= c_tmax_in;
      f_hit_ff[0]  <= c_hit_ff;
      f_tmin_ff[0] <= c_tmin_ff;
      f_tmax_ff[0] <= c_tmax_ff;
      for (int s = 1; s < FACE_LAT; s++) begin
         f_hit_ff[s]  <= f_hit_ff[s-1];
         f_tmin_ff[s] <= f_tmin_ff[s-1];
         f_tmax_ff[s] <= f_tmax_ff[s-1];
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         a_vld_ff      <= 1'b0;
         c_vld_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int s = 0; s < L_DIV; s++) svld_ff[s] <= 1'b0;
         for (int s = 0; s < FACE_LAT; s++) f_vld_ff[s] <= 1'b0;
      end else begin
         busy_ff    <= 1'b0;
         a_vld_ff   <= accept;
         svld_ff[0] <= a_vld_ff;
         for (int s = 1; s < L_DIV; s++) svld_ff[s] <= svld_ff[s-1];
         c_vld_ff    <= svld_ff[L_DIV-1];
         f_vld_ff[0] <= c_vld_ff;
         for (int s = 1; s < FACE_LAT; s++) f_vld_ff[s] <= f_vld_ff[s-1];
         rsp_strobe_ff <= f_vld_ff[FACE_LAT-1];
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   `RUSI_ASSERT_IMPL(a_miss_zero, clock, reset, rsp_strobe && !rsp_payload.is_hit, rsp_payload.t_enter == 32'sd0 && rsp_payload.t_exit == 32'sd0 && rsp_payload.exit_v == 17'd0)
   `RUSI_ASSERT_IMPL(a_hit_order, clock, reset, rsp_strobe && rsp_payload.is_hit, rsp_payload.t_enter <= rsp_payload.t_exit)
   `RUSI_ASSERT_IMPL(a_face_code, clock, reset, rsp_strobe, rsp_payload.enter_face <= FACE_NEG_Z && rsp_payload.exit_face <= FACE_NEG_Z)
   `RUSI_ASSERT_IMPL(a_uv_range, clock, reset, rsp_strobe, rsp_payload.enter_u <= UV_ONE && rsp_payload.enter_v <= UV_ONE && rsp_payload.exit_u <= UV_ONE && rsp_payload.exit_v <= UV_ONE)
   `RUSI_ASSERT(a_quiet_after_reset, clock, 1'b0, $past(reset) |-> !rsp_strobe && busy)

endmodule

// ===== hw/rtl/rusi_slab_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, BPS quotient bits per stage, saturating signed result.
module rusi_slab_div import rusi_pkg::*; #(
   parameter int NUM_W = 49,
   parameter int BPS   = DIV_BITS_PER_STAGE
) (
   input  logic               clock,
   input  logic [NUM_W-1:0]   num_mag,
   input  logic [31:0]        den_mag,
   input  logic               quo_neg,
   output logic signed [31:0] quo_sat
);

   localparam int NDS = (NUM_W + BPS - 1) / BPS;
   localparam int QW  = NDS * BPS;

   logic [31:0]   rem_ff [NDS];
   logic [QW-1:0] acc_ff [NDS];
   logic [31:0]   den_ff [NDS];
   logic          neg_ff [NDS];

   logic [31:0]   rem_in [NDS];
   logic [QW-1:0] acc_in [NDS];
   logic [31:0]   den_src [NDS];
   logic          neg_src [NDS];

   logic signed [31:0] quo_sat_ff, quo_sat_in;

   always_comb begin
      logic [32:0]   part;
      logic [31:0]   r;
      logic [QW-1:0] a;
      part = '0;
      r    = '0;
      a    = '0;
      for (int s = 0; s < NDS; s++) begin
         if (s == 0) begin
            r          = '0;
            a          = QW'(num_mag);
            den_src[s] = den_mag;
            neg_src[s] = quo_neg;
         end else begin
            r          = rem_ff[s-1];
            a          = acc_ff[s-1];
            den_src[s] = den_ff[s-1];
            neg_src[s] = neg_ff[s-1];
         end
         // numerator bits shift out the top, quotient bits shift in at the bottom
         for (int k = 0; k < BPS; k++) begin
            part = {r, a[QW-1]};
            a    = {a[QW-2:0], 1'b0};
            if (part >= {1'b0, den_src[s]}) begin
               part = part - {1'b0, den_src[s]};
               a[0] = 1'b1;
            end
            r = part[31:0];
         end
         rem_in[s] = r;
         acc_in[s] = a;
      end
   end

   always_comb begin
      logic [QW-1:0] q;
      q = acc_ff[NDS-1];
      if (neg_ff[NDS-1]) begin
         if (q > QW'(64'h8000_0000)) quo_sat_in = T_MIN;
         else                        quo_sat_in = -(q[31:0]);
      end else begin
         if (q > QW'(64'h7fff_ffff)) quo_sat_in = T_MAX;
         else                        quo_sat_in = q[31:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NDS; s++) begin
         rem_ff[s] <= rem_in[s];
         acc_ff[s] <= acc_in[s];
         den_ff[s] <= den_src[s];
         neg_ff[s] <= neg_src[s];
      end
      quo_sat_ff <= quo_sat_in;
   end

   assign quo_sat = quo_sat_ff;

endmodule

// ===== hw/rtl/rusi_face.sv =====
`timescale 1ns / 1ps
// Hit point, face pick and face uv; three register stages.
module rusi_face import rusi_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  req_type            ray,
   input  logic signed [31:0] t,
   output face_res_type       res
);

   localparam int PW   = 65 - FRAC_BITS;
   localparam int SH_R = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int SH_L = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam logic signed [PW:0] ONE_W = (PW+1)'(1) <<< FRAC_BITS;
   localparam logic [PW:0]        ONE_U = (PW+1)'(1) << FRAC_BITS;
   localparam logic signed [63:0] RND   = (64'sd1 <<< FRAC_BITS) - 64'sd1;

   logic signed [31:0]   o_a [3];
   logic signed [31:0]   d_a [3];
   logic signed [63:0]   prod_ff [3];
   logic signed [63:0]   prod_in [3];
   logic signed [31:0]   o1_ff [3];
   logic signed [PW-1:0] p_ff [3];
   logic signed [PW-1:0] p_in [3];
   face_res_type         res_ff, res_in;

   function automatic logic [16:0] to_q16(input logic signed [PW-1:0] c, input logic sneg);
      logic signed [PW:0] w;
      logic [PW:0]        u;
      logic [PW:0]        r;
      w = (PW+1)'(c);
      if (sneg) w = -w;
      w = w + ONE_W;
      r = '0;
      if (w > 0) begin
         u = w >> 1;
         if (u > ONE_U) u = ONE_U;
         r = (u >> SH_R) << SH_L;
      end
      return r[16:0];
   endfunction

   always_comb begin
      o_a[0] = ray.origin_x;
      o_a[1] = ray.origin_y;
      o_a[2] = ray.origin_z;
      d_a[0] = ray.dir_x;
      d_a[1] = ray.dir_y;
      d_a[2] = ray.dir_z;
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = 64'(d_a[i]) * 64'(t);
      end
   end

   // divide by 2^FRAC_BITS truncating toward zero
   always_comb begin
      logic signed [63:0] q;
      q = '0;
      for (int i = 0; i < 3; i++) begin
         if (prod_ff[i] < 0) q = (prod_ff[i] + RND) >>> FRAC_BITS;
         else                q = prod_ff[i] >>> FRAC_BITS;
         p_in[i] = PW'(o1_ff[i]) + q[PW-1:0];
      end
   end

   always_comb begin
      logic [PW-1:0] a [3];
      for (int i = 0; i < 3; i++) begin
         a[i] = p_ff[i][PW-1] ? PW'(-p_ff[i]) : PW'(p_ff[i]);
      end
      if (a[0] > a[1] && a[0] > a[2]) begin
         res_in.face = (p_ff[0] > 0) ? FACE_POS_X : FACE_NEG_X;
         res_in.u    = to_q16(p_ff[2], !(p_ff[0] > 0));
         res_in.v    = to_q16(p_ff[1], !(p_ff[0] > 0));
      end else if (a[1] > a[2]) begin
         res_in.face = (p_ff[1] > 0) ? FACE_POS_Y : FACE_NEG_Y;
         res_in.u    = to_q16(p_ff[0], !(p_ff[1] > 0));
         res_in.v    = to_q16(p_ff[2], !(p_ff[1] > 0));
      end else begin
         res_in.face = (p_ff[2] > 0) ? FACE_POS_Z : FACE_NEG_Z;
         res_in.u    = to_q16(p_ff[0], !(p_ff[2] > 0));
         res_in.v    = to_q16(p_ff[1], !(p_ff[2] > 0));
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         prod_ff[i] <= prod_in[i];
         o1_ff[i]   <= o_a[i];
         p_ff[i]    <= p_in[i];
      end
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

// ===== dv/ray_unit_box_slab_intersect_test.sv =====
`timescale 1ns / 1ps
module ray_unit_box_slab_intersect_test;
   import rusi_pkg::*;

   localparam int FRAC   = FRAC_BITS_DEF;
   localparam int LAT    = 20;
   localparam int LIMIT  = 400000;
   localparam int N_RAND = 1800;
   localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC;
   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC - 1);

   typedef struct {
      req_type ray;
      logic    known;
      rsp_type want;
   } ray_row_type;

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   rsp_type     pending_hits[$];
   ray_row_type rows[$];
   int          errors = 0;
   int          cycles = 0;
   logic        quiet = 0;

   ray_unit_box_slab_intersect dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   function automatic logic signed [63:0] sat_t(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic slab_range(input logic signed [63:0] o, d,
                                       output logic signed [63:0] tn, tf);
      logic signed [63:0] bn;
      if (d == 0) begin
         if (o < -HALF || o > HALF) return 0;
         tn = -64'sd2147483648;
         tf = 64'sd2147483647;
         return 1;
      end
      bn = d < 0 ? HALF : -HALF;
      tn = sat_t(((bn - o) * ONE) / d);
      tf = sat_t(((-bn - o) * ONE) / d);
      return 1;
   endfunction

   function automatic logic [16:0] face_coord(input logic signed [63:0] c, s);
      logic signed [63:0] w;
      logic signed [63:0] h;
      w = s * c + ONE;
      if (w <= 0) return '0;
      h = w / 2;
      if (h > ONE) h = ONE;
      if (FRAC > 16) return 17'(h >>> (FRAC - 16));
      return 17'(h <<< (16 - FRAC));
   endfunction

   function automatic face_res_type face_at(input logic signed [63:0] o[3], d[3],
                                            input logic signed [63:0] t);
      logic signed [63:0] p[3], a[3], s;
      face_res_type f;
      for (int i = 0; i < 3; i++) begin
         p[i] = o[i] + (d[i] * t) / ONE;
         a[i] = p[i] < 0 ? -p[i] : p[i];
      end
      if (a[0] > a[1] && a[0] > a[2]) begin
         s = p[0] > 0 ? 1 : -1;
         f.face = s > 0 ? FACE_POS_X : FACE_NEG_X;
         f.u = face_coord(p[2], s);
         f.v = face_coord(p[1], s);
      end else if (a[1] > a[2]) begin
         s = p[1] > 0 ? 1 : -1;
         f.face = s > 0 ? FACE_POS_Y : FACE_NEG_Y;
         f.u = face_coord(p[0], s);
         f.v = face_coord(p[2], s);
      end else begin
         s = p[2] > 0 ? 1 : -1;
         f.face = s > 0 ? FACE_POS_Z : FACE_NEG_Z;
         f.u = face_coord(p[0], s);
         f.v = face_coord(p[1], s);
      end
      return f;
   endfunction

   function automatic rsp_type intersect_box(input req_type r);
      logic signed [63:0] o[3], d[3], tmin, tmax, tn, tf;
      logic hit;
      rsp_type y;
      face_res_type fe, fx;
      o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
      d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
      y = '0;
      hit = slab_range(o[0], d[0], tmin, tmax);
      for (int i = 1; i < 3 && hit; i++) begin
         if (!slab_range(o[i], d[i], tn, tf)) hit = 0;
         else begin
            if (tmin > tf || tn > tmax) hit = 0;
            if (tn > tmin) tmin = tn;
            if (tf < tmax) tmax = tf;
         end
      end
      if (!hit) return y;
      fe = face_at(o, d, tmin);
      fx = face_at(o, d, tmax);
      y.is_hit = 1;
      y.t_enter = tmin[31:0];
      y.t_exit = tmax[31:0];
      y.enter_face = fe.face; y.enter_u = fe.u; y.enter_v = fe.v;
      y.exit_face = fx.face;  y.exit_u = fx.u;  y.exit_v = fx.v;
      return y;
   endfunction

   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_strobe) begin
         if (pending_hits.size() == 0) report_mismatch("unexpected result", 0, 0);
         else begin
            w = pending_hits.pop_front();
            if (rsp_payload.is_hit !== w.is_hit)
               report_mismatch("is_hit", rsp_payload.is_hit, w.is_hit);
            if (rsp_payload.t_enter !== w.t_enter)
               report_mismatch("t_enter", rsp_payload.t_enter, w.t_enter);
            if (rsp_payload.t_exit !== w.t_exit)
               report_mismatch("t_exit", rsp_payload.t_exit, w.t_exit);
            if (rsp_payload.enter_face !== w.enter_face)
               report_mismatch("enter_face", rsp_payload.enter_face, w.enter_face);
            if (rsp_payload.exit_face !== w.exit_face)
               report_mismatch("exit_face", rsp_payload.exit_face, w.exit_face);
            if (rsp_payload.enter_u !== w.enter_u)
               report_mismatch("enter_u", rsp_payload.enter_u, w.enter_u);
            if (rsp_payload.enter_v !== w.enter_v)
               report_mismatch("enter_v", rsp_payload.enter_v, w.enter_v);
            if (rsp_payload.exit_u !== w.exit_u)
               report_mismatch("exit_u", rsp_payload.exit_u, w.exit_u);
            if (rsp_payload.exit_v !== w.exit_v)
               report_mismatch("exit_v", rsp_payload.exit_v, w.exit_v);
         end
      end
   end

   function automatic req_type mk(input int ox, oy, oz, dx, dy, dz);
      req_type r;
      r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
      r.dir_x = dx;    r.dir_y = dy;    r.dir_z = dz;
      return r;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(4 * 65536)) - 2 * 65536);
         2: return 32'($signed($urandom_range(65536)) - 32768);
         3: return $urandom_range(2) == 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
         4: return $urandom_range(2) == 0 ? 32'(-32768) : 32'd32768;
         default: return $urandom_range(3) == 0 ? 32'd0 : 32'($signed($urandom_range(16)) - 8);
      endcase
   endfunction

   // a ray from a random origin aimed at a random point in the box, x or y dir sometimes zeroed
   function automatic req_type aimed_ray();
      req_type r;
      r = mk(rand_coord(), rand_coord(), rand_coord(), 0, 0, 0);
      if ($urandom_range(3) != 0) begin
         r.origin_x = 32'($signed($urandom_range(6 * 65536)) - 3 * 65536);
         r.origin_y = 32'($signed($urandom_range(6 * 65536)) - 3 * 65536);
         r.origin_z = 32'($signed($urandom_range(6 * 65536)) - 3 * 65536);
      end
      r.dir_x = 32'($signed($urandom_range(65536)) - 32768) - r.origin_x;
      r.dir_y = 32'($signed($urandom_range(65536)) - 32768) - r.origin_y;
      r.dir_z = 32'($signed($urandom_range(65536)) - 32768) - r.origin_z;
      if ($urandom_range(5) == 0) r.dir_x = 0;
      if ($urandom_range(5) == 0) r.dir_y = 0;
      return r;
   endfunction

   task automatic send_ray(input req_type r, input logic gaps);
      if (gaps && !quiet) begin
         while ($urandom_range(99) < 13) begin
            start <= 0;
            @(posedge clock);
         end
      end
      start <= 1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_hits.push_back(intersect_box(r));
   endtask

   initial begin
      ray_row_type row;
      rsp_type miss;
      miss = '0;
      row.known = 1; row.want = miss;
      row.ray = mk(0, 0, 0, 0, 0, 0); row.known = 0; rows.push_back(row);
      row.known = 1;
      row.ray = mk(32769, 0, 0, 0, 0, 0); rows.push_back(row);       // outside, zero dir
      row.ray = mk(0, -32769, 0, 65536, 0, 0); rows.push_back(row);
      row.ray = mk(0, 0, 32'sh7fff_ffff, 65536, 65536, 0); rows.push_back(row);
      row.ray = mk(32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0); rows.push_back(row);
      row.known = 0;
      row.ray = mk(32768, 32768, -32768, 0, 0, 0); rows.push_back(row); // on the edge
      row.ray = mk(-131072, 0, 0, 65536, 0, 0); rows.push_back(row);
      row.ray = mk(131072, 0, 0, -65536, 0, 0); rows.push_back(row);
      row.ray = mk(0, -131072, 0, 0, 65536, 0); rows.push_back(row);
      row.ray = mk(0, 0, 131072, 0, 0, -65536); rows.push_back(row);
      row.ray = mk(-131072, -131072, -131072, 65536, 65536, 65536); rows.push_back(row);
      row.ray = mk(0, 0, 0, 1, 1, 1); rows.push_back(row);           // saturated t
      row.ray = mk(0, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff, -1); rows.push_back(row);
      row.ray = mk(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                   32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000); rows.push_back(row);
      row.ray = mk(-1, -1, -1, -1, -1, -1); rows.push_back(row);
      row.ray = mk(-65536, 10000, 10000, 65536, 0, 0); rows.push_back(row);
      row.ray = mk(0, -65536, 0, 65536, 65536, 0); rows.push_back(row); // x/y tie
      row.ray = mk(0, 0, 0, 65536, 65536, 65536); rows.push_back(row);  // full tie
      row.ray = mk(40000, 0, 0, 0, 65536, 0); rows.push_back(row);
      row.ray = mk(0, 0, 0, 0, 0, 65536); rows.push_back(row);

      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (rows[i]) begin
         send_ray(rows[i].ray, 1);
         if (rows[i].known) begin
            pending_hits.pop_back();
            pending_hits.push_back(rows[i].want);
         end
      end
      start <= 0;
      // drain fully before the random part
      while (pending_hits.size() != 0) @(posedge clock);

      for (int n = 0; n < N_RAND; n++) begin
         quiet = (n >= 600 && n < 800);
         if ($urandom_range(3) == 0)
            send_ray(mk(rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord()), 1);
         else
            send_ray(aimed_ray(), 1);
      end
      start <= 0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (LAT + 5) @(posedge clock);
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
